FILE: hdl/rotation_to_euler_zyx_defines.svh
// Assertion macros shared by the rotation-to-Euler checker.
`ifndef ROTATION_TO_EULER_ZYX_DEFINES_SVH
`define ROTATION_TO_EULER_ZYX_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define R2E_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotation_to_euler_zyx: assertion failed");

// The antecedent implies the consequent in the next cycle.
`define R2E_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotation_to_euler_zyx: assertion failed");

`endif

FILE: hdl/r2e_pkg.sv
// Types, constants and helper functions for the rotation-to-Euler pipeline.
`default_nettype none

package r2e_pkg;

  localparam int IN_W         = 16;
  localparam int GUARD_BITS   = 14;
  localparam int ANGLE_FRAC   = 8;
  localparam int SUMSQ_W      = 2 * IN_W;
  localparam int ROOT_W       = (SUMSQ_W + 2 * GUARD_BITS) / 2;
  localparam int REM_W        = ROOT_W + 2;
  localparam int XY_W         = 32;
  localparam int Z_W          = 25;
  localparam int ANG_W        = Z_W - ANGLE_FRAC;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CELLS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W       = $clog2(TABLE_LEN);
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int ROLL_W       = 16;
  localparam int PITCH_W      = 15;
  localparam int YAW_W        = 16;

  localparam int LANES      = 3;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(HALF_TURN * (1 << ANGLE_FRAC));
  localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(QUARTER_TURN * (1 << ANGLE_FRAC));
  localparam logic signed [Z_W-1:0] Z_ROUND   = Z_W'(1 << (ANGLE_FRAC - 1));
  localparam logic signed [ANG_W-1:0] LIM_HALF    = ANG_W'(HALF_TURN);
  localparam logic signed [ANG_W-1:0] LIM_QUARTER = ANG_W'(QUARTER_TURN);

  // atan(2^-i) in 1/32768 degree
  localparam logic signed [Z_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
    25'sd1474560, 25'sd870484, 25'sd459940, 25'sd233473,
    25'sd117189,  25'sd58652,  25'sd29333,  25'sd14667,
    25'sd7334,    25'sd3667,   25'sd1833,   25'sd917,
    25'sd458,     25'sd229,    25'sd115,    25'sd57,
    25'sd29,      25'sd14,     25'sd7,      25'sd4,
    25'sd2,       25'sd1,      25'sd0,      25'sd0
  };

  typedef struct packed {
    logic signed [IN_W-1:0] m00;
    logic signed [IN_W-1:0] m10;
    logic signed [IN_W-1:0] m20;
    logic signed [IN_W-1:0] m21;
    logic signed [IN_W-1:0] m22;
  } mat_t;

  typedef struct packed {
    mat_t                mat;
    logic [SUMSQ_W-1:0]  rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    logic                   fixed;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } lane_t;

  typedef lane_t [LANES-1:0] lanes_t;

  function automatic logic signed [XY_W-1:0] scale(input logic signed [IN_W-1:0] m);
    scale = XY_W'(m) <<< GUARD_BITS;
  endfunction

  // settle the axis cases and fold the left half-plane into the right
  function automatic lane_t prerot(input logic signed [XY_W-1:0] y,
                                   input logic signed [XY_W-1:0] x);
    lane_t l;
    l.fixed = 1'b0;
    l.x     = x;
    l.y     = y;
    l.z     = '0;
    if (y == '0) begin
      l.fixed = 1'b1;
      l.z     = x[XY_W-1] ? Z_HALF : '0;
    end else if (x == '0) begin
      l.fixed = 1'b1;
      l.z     = y[XY_W-1] ? -Z_QUARTER : Z_QUARTER;
    end else if (x[XY_W-1]) begin
      l.z = y[XY_W-1] ? -Z_HALF : Z_HALF;
      l.x = -x;
      l.y = -y;
    end
    return l;
  endfunction

  function automatic logic signed [ANG_W-1:0] round_clamp(input logic signed [Z_W-1:0] z,
                                                          input logic signed [ANG_W-1:0] lim);
    logic signed [Z_W-1:0]   t;
    logic signed [ANG_W-1:0] r;
    t = z + Z_ROUND;
    r = t[Z_W-1:ANGLE_FRAC];
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rotation_to_euler_zyx.sv
// Top level: rotation matrix entries in, ZYX Euler angles out.
// Input channel: valid/stall carrying valid_req and m00, m10, m20, m21, m22
// (signed Q1.14). A request is taken at a clock edge with valid high and
// stall low. A request with valid_req low is taken and gives no result.
// Result channel: result_valid/result_stall carrying roll, pitch and yaw in
// 1/128 degree; a result is taken when result_valid is high and
// result_stall is low.
// The path runs through the squares register, the sum register, 30
// square-root cells, one pre-rotation stage, one CORDIC cell per step and
// the output register. One request enters every cycle while stall is low;
// every cell of the chain advances together.
// A two-entry output buffer (output register plus skid register) lets a
// request enter while a result waits. When a further result arrives while
// the receiver stalls, the skid register fills and raises stall, which holds
// the whole chain until the receiver takes a result. Reset clears all valid
// bits, so the block comes out of reset empty and ready.
`default_nettype none

module rotation_to_euler_zyx (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid,
  output logic                                stall,
  input  logic                                valid_req,
  input  logic signed [r2e_pkg::IN_W-1:0]     m00,
  input  logic signed [r2e_pkg::IN_W-1:0]     m10,
  input  logic signed [r2e_pkg::IN_W-1:0]     m20,
  input  logic signed [r2e_pkg::IN_W-1:0]     m21,
  input  logic signed [r2e_pkg::IN_W-1:0]     m22,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [r2e_pkg::ROLL_W-1:0]   roll,
  output logic signed [r2e_pkg::PITCH_W-1:0]  pitch,
  output logic signed [r2e_pkg::YAW_W-1:0]    yaw
);
  import r2e_pkg::*;

  logic adv;

  logic                       s1_v;
  mat_t                       s1_mat;
  logic signed [SUMSQ_W-1:0]  sq21;
  logic signed [SUMSQ_W-1:0]  sq22;

  logic                       s2_v;
  mat_t                       s2_mat;
  logic [SUMSQ_W-1:0]         s2_sum;

  logic                       sq_v [0:ROOT_W];
  sqrt_t                      sq_s [0:ROOT_W];

  logic                       pr_v;
  lanes_t                     pr_l;

  logic                       cv [0:CORDIC_CELLS];
  lanes_t                     cl [0:CORDIC_CELLS];

  logic signed [ANG_W-1:0]    fin_roll;
  logic signed [ANG_W-1:0]    fin_pitch;
  logic signed [ANG_W-1:0]    fin_yaw;
  logic                       last_v;

  logic                       main_v;
  logic                       skid_v;
  logic signed [ROLL_W-1:0]   main_roll;
  logic signed [PITCH_W-1:0]  main_pitch;
  logic signed [YAW_W-1:0]    main_yaw;
  logic signed [ROLL_W-1:0]   skid_roll;
  logic signed [PITCH_W-1:0]  skid_pitch;
  logic signed [YAW_W-1:0]    skid_yaw;

  assign stall = skid_v;
  assign adv   = !skid_v;

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= valid && valid_req;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mat.m00 <= m00;
      s1_mat.m10 <= m10;
      s1_mat.m20 <= m20;
      s1_mat.m21 <= m21;
      s1_mat.m22 <= m22;
      sq21       <= m21 * m21;
      sq22       <= m22 * m22;
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mat <= s1_mat;
      s2_sum <= SUMSQ_W'(sq21) + SUMSQ_W'(sq22);
    end
  end

  // square-root chain
  assign sq_v[0]      = s2_v;
  assign sq_s[0].mat  = s2_mat;
  assign sq_s[0].rad  = s2_sum;
  assign sq_s[0].rem  = '0;
  assign sq_s[0].root = '0;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    r2e_sqrt_cell u_sqrt (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .in_v  (sq_v[g]),
      .in_s  (sq_s[g]),
      .out_v (sq_v[g+1]),
      .out_s (sq_s[g+1])
    );
  end

  // pre-rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      pr_v <= 1'b0;
    end else if (adv) begin
      pr_v <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_l[LANE_ROLL]  <= prerot(scale(sq_s[ROOT_W].mat.m21), scale(sq_s[ROOT_W].mat.m22));
      pr_l[LANE_PITCH] <= prerot(-scale(sq_s[ROOT_W].mat.m20), XY_W'(sq_s[ROOT_W].root));
      pr_l[LANE_YAW]   <= prerot(scale(sq_s[ROOT_W].mat.m10), scale(sq_s[ROOT_W].mat.m00));
    end
  end

  // CORDIC chain
  assign cv[0] = pr_v;
  assign cl[0] = pr_l;

  for (genvar g = 0; g < CORDIC_CELLS; g++) begin : g_cordic
    r2e_cordic_cell u_cordic (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .step  (STEP_W'(g)),
      .in_v  (cv[g]),
      .in_l  (cl[g]),
      .out_v (cv[g+1]),
      .out_l (cl[g+1])
    );
  end

  assign last_v    = cv[CORDIC_CELLS];
  assign fin_roll  = round_clamp(cl[CORDIC_CELLS][LANE_ROLL].z, LIM_HALF);
  assign fin_pitch = round_clamp(cl[CORDIC_CELLS][LANE_PITCH].z, LIM_QUARTER);
  assign fin_yaw   = round_clamp(cl[CORDIC_CELLS][LANE_YAW].z, LIM_HALF);

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (!result_stall) begin
        main_v <= 1'b1;
        skid_v <= 1'b0;
      end
    end else if (last_v) begin
      if (main_v && result_stall) begin
        skid_v <= 1'b1;
      end else begin
        main_v <= 1'b1;
      end
    end else if (!result_stall) begin
      main_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (!result_stall) begin
        main_roll  <= skid_roll;
        main_pitch <= skid_pitch;
        main_yaw   <= skid_yaw;
      end
    end else if (last_v) begin
      if (main_v && result_stall) begin
        skid_roll  <= ROLL_W'(fin_roll);
        skid_pitch <= PITCH_W'(fin_pitch);
        skid_yaw   <= YAW_W'(fin_yaw);
      end else begin
        main_roll  <= ROLL_W'(fin_roll);
        main_pitch <= PITCH_W'(fin_pitch);
        main_yaw   <= YAW_W'(fin_yaw);
      end
    end
  end

  assign result_valid = main_v;
  assign roll         = main_roll;
  assign pitch        = main_pitch;
  assign yaw          = main_yaw;

endmodule

`default_nettype wire

FILE: hdl/r2e_sqrt_cell.sv
// One restoring square-root step: takes two radicand bits, yields one root bit.
`default_nettype none

module r2e_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_v,
  input  r2e_pkg::sqrt_t  in_s,
  output logic            out_v,
  output r2e_pkg::sqrt_t  out_s
);
  import r2e_pkg::*;

  logic [REM_W+1:0] cur;
  logic [REM_W+1:0] trial;
  logic             take;
  sqrt_t            nxt;

  always_comb begin
    cur      = {in_s.rem, in_s.rad[SUMSQ_W-1 -: 2]};
    trial    = (REM_W + 2)'({in_s.root, 2'b01});
    take     = (cur >= trial);
    nxt.mat  = in_s.mat;
    nxt.rad  = in_s.rad << 2;
    nxt.rem  = take ? REM_W'(cur - trial) : REM_W'(cur);
    nxt.root = {in_s.root[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_s <= nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/r2e_cordic_cell.sv
// One vectoring CORDIC step applied to the roll, pitch and yaw lanes.
`default_nettype none

module r2e_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [r2e_pkg::STEP_W-1:0]    step,
  input  logic                          in_v,
  input  r2e_pkg::lanes_t               in_l,
  output logic                          out_v,
  output r2e_pkg::lanes_t               out_l
);
  import r2e_pkg::*;

  lanes_t nxt;

  always_comb begin
    nxt = in_l;
    for (int k = 0; k < LANES; k++) begin
      if (!in_l[k].fixed) begin
        if (!in_l[k].y[XY_W-1]) begin
          nxt[k].x = $signed(in_l[k].x) + ($signed(in_l[k].y) >>> step);
          nxt[k].y = $signed(in_l[k].y) - ($signed(in_l[k].x) >>> step);
          nxt[k].z = $signed(in_l[k].z) + ATAN_TABLE[step];
        end else begin
          nxt[k].x = $signed(in_l[k].x) - ($signed(in_l[k].y) >>> step);
          nxt[k].y = $signed(in_l[k].y) + ($signed(in_l[k].x) >>> step);
          nxt[k].z = $signed(in_l[k].z) - ATAN_TABLE[step];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_l <= nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/r2e_checker.sv
// Port-level checks on the result channel of the rotation-to-Euler block.
`default_nettype none

`include "rotation_to_euler_zyx_defines.svh"

module r2e_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic signed [15:0] roll,
  input  logic signed [14:0] pitch,
  input  logic signed [15:0] yaw
);

  `R2E_ASSERT_NXT(a_hold_valid, result_valid && result_stall, result_valid)
  `R2E_ASSERT_NXT(a_hold_data, result_valid && result_stall, $stable(roll) && $stable(pitch) && $stable(yaw))
  `R2E_ASSERT_IMP(a_roll_range, result_valid, roll <= 16'sd23040 && roll >= -16'sd23040)
  `R2E_ASSERT_IMP(a_pitch_range, result_valid, pitch <= 15'sd11520 && pitch >= -15'sd11520)
  `R2E_ASSERT_IMP(a_yaw_range, result_valid, yaw <= 16'sd23040 && yaw >= -16'sd23040)

endmodule

bind rotation_to_euler_zyx r2e_checker u_r2e_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .roll         (roll),
  .pitch        (pitch),
  .yaw          (yaw)
);

`default_nettype wire

FILE: dv/rotation_to_euler_zyx_test.sv
// Self-checking test of rotation_to_euler_zyx: CORDIC angle prediction under random stalls.
`default_nettype none

module rotation_to_euler_zyx_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_ITERS = 16;
  localparam int ATAN_LEN = 24;
  localparam longint HALF_DEG = 23040;
  localparam longint QUARTER_DEG = 11520;
  localparam int FRAC_BITS = 8;
  localparam int SCALE_BITS = 14;
  localparam int HOLD_AT = 250;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 60000;
  localparam int RANDOM_POSES = 1000;

  localparam longint ATAN_Q15 [0:ATAN_LEN-1] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  typedef struct packed {
    logic          vreq;
    r2e_pkg::mat_t mat;
  } pose_req_t;

  typedef struct packed {
    logic signed [r2e_pkg::ROLL_W-1:0]  roll;
    logic signed [r2e_pkg::PITCH_W-1:0] pitch;
    logic signed [r2e_pkg::YAW_W-1:0]   yaw;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic stall;
  logic valid_req = 1'b0;
  logic signed [r2e_pkg::IN_W-1:0] m00 = '0;
  logic signed [r2e_pkg::IN_W-1:0] m10 = '0;
  logic signed [r2e_pkg::IN_W-1:0] m20 = '0;
  logic signed [r2e_pkg::IN_W-1:0] m21 = '0;
  logic signed [r2e_pkg::IN_W-1:0] m22 = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [r2e_pkg::ROLL_W-1:0]  roll;
  logic signed [r2e_pkg::PITCH_W-1:0] pitch;
  logic signed [r2e_pkg::YAW_W-1:0]   yaw;

  pose_req_t pose_queue [$];
  euler_t    angle_queue [$];
  pose_req_t offer;
  int        total_poses = 0;
  int        sent_count = 0;
  int        got_count = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  rotation_to_euler_zyx u_dut (
    .clk          (clk),
    .rst          (rst),
    .valid        (valid),
    .stall        (stall),
    .valid_req    (valid_req),
    .m00          (m00),
    .m10          (m10),
    .m20          (m20),
    .m21          (m21),
    .m22          (m22),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .roll         (roll),
    .pitch        (pitch),
    .yaw          (yaw)
  );

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n = n - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    longint r;
    if (y == 0) return (x < 0) ? HALF_DEG : 0;
    if (x == 0) return (y > 0) ? QUARTER_DEG : -QUARTER_DEG;
    z = 0;
    if (x < 0) begin
      z = (y > 0) ? (HALF_DEG << FRAC_BITS) : -(HALF_DEG << FRAC_BITS);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_ITERS && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_Q15[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_Q15[i];
      end
    end
    r = (z + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > HALF_DEG) r = HALF_DEG;
    if (r < -HALF_DEG) r = -HALF_DEG;
    return r;
  endfunction

  function automatic euler_t euler_of(r2e_pkg::mat_t mat);
    euler_t e;
    longint a00;
    longint a10;
    longint a20;
    longint a21;
    longint a22;
    longint den;
    longint p;
    longint unsigned sumsq;
    a00 = longint'(mat.m00);
    a10 = longint'(mat.m10);
    a20 = longint'(mat.m20);
    a21 = longint'(mat.m21);
    a22 = longint'(mat.m22);
    e.roll = r2e_pkg::ROLL_W'(cordic_angle(a21 <<< SCALE_BITS, a22 <<< SCALE_BITS));
    sumsq = longint'(a21 * a21 + a22 * a22);
    den = longint'(root_floor(sumsq << (2 * SCALE_BITS)));
    p = cordic_angle((-a20) <<< SCALE_BITS, den);
    if (p > QUARTER_DEG) p = QUARTER_DEG;
    if (p < -QUARTER_DEG) p = -QUARTER_DEG;
    e.pitch = r2e_pkg::PITCH_W'(p);
    e.yaw = r2e_pkg::YAW_W'(cordic_angle(a10 <<< SCALE_BITS, a00 <<< SCALE_BITS));
    return e;
  endfunction

  task automatic push_pose(bit vreq, int a00, int a10, int a20, int a21, int a22);
    pose_req_t p;
    p.vreq = vreq;
    p.mat.m00 = r2e_pkg::IN_W'(a00);
    p.mat.m10 = r2e_pkg::IN_W'(a10);
    p.mat.m20 = r2e_pkg::IN_W'(a20);
    p.mat.m21 = r2e_pkg::IN_W'(a21);
    p.mat.m22 = r2e_pkg::IN_W'(a22);
    pose_queue = {pose_queue, p};
  endtask

  function automatic int pick_entry();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return int'($urandom_range(32768)) - 16384;
    if (sel < 70) return int'($urandom_range(65535)) - 32768;
    if (sel < 82) return int'($urandom_range(6)) - 3;
    if (sel < 92) return 0;
    case ($urandom_range(3))
      0: return 16384;
      1: return -16384;
      2: return 32767;
      default: return -32768;
    endcase
  endfunction

  task automatic push_rotation();
    real r;
    real p;
    real y;
    real k;
    k = 3.14159265358979 / 1800.0;
    r = (real'($urandom_range(3599)) - 1800.0) * k;
    p = (real'($urandom_range(1800)) - 900.0) * k;
    y = (real'($urandom_range(3599)) - 1800.0) * k;
    push_pose($urandom_range(99) >= 8,
              $rtoi(16384.0 * $cos(y) * $cos(p)), $rtoi(16384.0 * $sin(y) * $cos(p)),
              $rtoi(-16384.0 * $sin(p)), $rtoi(16384.0 * $cos(p) * $sin(r)),
              $rtoi(16384.0 * $cos(p) * $cos(r)));
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // sender: hold a stalled request, idle at random outside the quiet window
  always @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (valid && !stall) begin
        if (offer.vreq) angle_queue = {angle_queue, euler_of(offer.mat)};
        sent_count++;
      end
      if (!valid || !stall) begin
        if (pose_queue.size() > 0 &&
            ((sent_count >= 500 && sent_count < 700) || $urandom_range(99) >= 19)) begin
          offer = pose_queue.pop_front();
          valid <= 1'b1;
          valid_req <= offer.vreq;
          m00 <= offer.mat.m00;
          m10 <= offer.mat.m10;
          m20 <= offer.mat.m20;
          m21 <= offer.mat.m21;
          m22 <= offer.mat.m22;
        end else begin
          valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result, then pick the next stall
  always @(posedge clk) begin
    euler_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got_count++;
        if (angle_queue.size() == 0) begin
          $error("unexpected result: roll %0d pitch %0d yaw %0d", roll, pitch, yaw);
          error_count++;
        end else begin
          want = angle_queue.pop_front();
          if (roll !== want.roll) begin
            $error("roll: expected %0d, got %0d", want.roll, roll);
            error_count++;
          end
          if (pitch !== want.pitch) begin
            $error("pitch: expected %0d, got %0d", want.pitch, pitch);
            error_count++;
          end
          if (yaw !== want.yaw) begin
            $error("yaw: expected %0d, got %0d", want.yaw, yaw);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (!hold_done && got_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        result_stall <= 1'b1;
      end else if (got_count >= 450 && got_count < 650) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < 19);
      end
    end
  end

  initial begin
    push_pose(1'b0, 16384, 0, 0, 0, 16384);
    push_pose(1'b1, 16384, 0, 0, 0, 16384);
    push_pose(1'b1, 0, 0, 0, 0, 0);
    push_pose(1'b1, -16384, 0, 0, 0, -16384);
    push_pose(1'b1, 0, 16384, 0, 16384, 0);
    push_pose(1'b1, 0, -16384, 0, -16384, 0);
    push_pose(1'b1, 0, 0, -16384, 0, 0);
    push_pose(1'b1, 0, 0, 16384, 0, 0);
    push_pose(1'b1, -16384, 1, 0, 5000, -10000);
    push_pose(1'b1, -16384, -1, 0, -5000, -10000);
    push_pose(1'b1, 11585, 11585, -11585, 8192, 8192);
    push_pose(1'b1, -32768, -32768, -32768, -32768, -32768);
    push_pose(1'b1, 32767, 32767, 32767, 32767, 32767);
    push_pose(1'b1, 32767, -32768, -32768, 32767, -32768);
    push_pose(1'b1, 1, -1, 1, -1, 1);
    push_pose(1'b1, -1, 1, -1, 1, -1);
    push_pose(1'b1, 16384, -16384, 16384, -16384, 16384);
    push_pose(1'b1, 0, 0, -32768, 0, 0);
    push_pose(1'b1, 100, 16384, 0, 16384, 100);
    push_pose(1'b0, -32768, 32767, -32768, 32767, -32768);
    for (int n = 0; n < RANDOM_POSES; n++) begin
      if ($urandom_range(99) < 55) begin
        push_rotation();
      end else begin
        push_pose($urandom_range(99) >= 8, pick_entry(), pick_entry(), pick_entry(),
                  pick_entry(), pick_entry());
      end
    end
    total_poses = pose_queue.size();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (sent_count < total_poses) @(posedge clk);
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (angle_queue.size() != 0) begin
      $error("%0d results never arrived", angle_queue.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
